FILE: rtl/acmac_pkg.sv
package acmac_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_SUBK,
    ST_BLOCK,
    ST_OUT
  } state_t;

  localparam int unsigned BLK_W = 128;
  localparam int unsigned KEY_W = 256;
  localparam logic [7:0] DBL_POLY = 8'h87;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_W0 = 3'd1;
  localparam logic [2:0] REG_KEY_W1 = 3'd2;
  localparam logic [2:0] REG_KEY_W2 = 3'd3;
  localparam logic [2:0] REG_KEY_W3 = 3'd4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // one aes round without the key add; byte 0 is bits 127:120
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        sb[4*c+row] = SBOX[s[127 - 8*(4*((c+row)%4)+row) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (final_rnd) begin
        t[4*c] = a0; t[4*c+1] = a1; t[4*c+2] = a2; t[4*c+3] = a3;
      end else begin
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
    aes_round = r;
  endfunction

endpackage

FILE: rtl/acmac_kexp.sv
module acmac_kexp import acmac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [1:0]   key_size,
  input  logic [255:0] key,
  input  logic [3:0]   rd_idx,
  output logic [127:0] rd_key,
  output logic         done,
  output logic [3:0]   nr
);
  // one key schedule word per cycle, packed four to a round key
  logic [127:0] rkmem [15];
  logic [255:0] win_r, win_nxt;
  logic [5:0]  i_r, i_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  rcon_r, rcon_nxt;
  logic        busy_r, busy_nxt;
  logic [3:0]  nk_r, nk_nxt;
  logic [3:0]  nr_r, nr_nxt;
  logic [5:0]  total;
  logic [31:0] t, neww, prev, oldw;
  logic [127:0] rd_r;

  assign total = {nr_r, 2'b00} + 6'd4;
  // window holds the last nk words, oldest at top
  assign prev = win_r[31:0];
  assign oldw = (nk_r == 4'd4) ? win_r[127:96] : (nk_r == 4'd6) ? win_r[191:160]
              : win_r[255:224];

  always_comb begin
    t = prev;
    if (pos_r == 3'd0) t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_r, 24'h0};
    else if (nk_r == 4'd8 && pos_r == 3'd4) t = sub_word(prev);
    neww = oldw ^ t;
  end

  always_comb begin
    win_nxt = win_r; i_nxt = i_r; pos_nxt = pos_r; rcon_nxt = rcon_r;
    busy_nxt = busy_r; nk_nxt = nk_r; nr_nxt = nr_r;
    if (start) begin
      busy_nxt = 1'b1;
      unique case (key_size)
        2'd0: begin nk_nxt = 4'd4; nr_nxt = 4'd10; win_nxt = {128'h0, key[255:128]}; end
        2'd1: begin nk_nxt = 4'd6; nr_nxt = 4'd12; win_nxt = {64'h0, key[255:64]}; end
        default: begin nk_nxt = 4'd8; nr_nxt = 4'd14; win_nxt = key; end
      endcase
      i_nxt = {2'b00, nk_nxt};
      pos_nxt = 3'd0;
      rcon_nxt = 8'h01;
    end else if (busy_r) begin
      win_nxt = {win_r[223:0], neww};
      i_nxt = i_r + 6'd1;
      pos_nxt = (pos_r == 3'(nk_r - 4'd1)) ? 3'd0 : pos_r + 3'd1;
      if (pos_r == 3'd0) rcon_nxt = xtime(rcon_r);
      if (i_r == total - 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; nr_r <= 4'd10; nk_r <= 4'd4;
    end else begin
      busy_r <= busy_nxt; nr_r <= nr_nxt; nk_r <= nk_nxt;
    end
    win_r <= win_nxt; i_r <= i_nxt; pos_r <= pos_nxt; rcon_r <= rcon_nxt;
  end

  // key words land in round keys 0 and 1 at start, then one word a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rkmem[0] <= key[255:128];
      rkmem[1] <= key[127:0];
    end else if (busy_r) begin
      rkmem[i_r[5:2]][127 - 32*i_r[1:0] -: 32] <= neww;
    end
    rd_r <= rkmem[rd_idx];
  end

  assign rd_key = rd_r;
  assign done = !busy_r && !start;
  assign nr = nr_r;
endmodule

FILE: rtl/acmac_round.sv
module acmac_round import acmac_pkg::*; (
  input  logic         clk,
  input  logic         start,
  input  logic [127:0] blk,
  input  logic [127:0] rkey,
  input  logic         key0,
  input  logic         final_rnd,
  output logic [127:0] nxt_state
);
  // shared round unit: one aes round per cycle while start is high, on a held state
  logic [127:0] st_r, st_nxt;
  always_comb begin
    if (key0) st_nxt = blk ^ rkey;
    else st_nxt = aes_round(st_r, final_rnd) ^ rkey;
  end
  always_ff @(posedge clk) begin
    if (start) st_r <= st_nxt;
  end
  assign nxt_state = st_nxt;
endmodule

FILE: rtl/aes_cmac_engine_core.sv
// aes-cmac engine, one 16-byte message word in, one 128-bit mac out
// in channel: tdata = data_hi [63:0], data_lo [127:64], valid_bytes [132:128];
//   tlast marks the final word of a message
// out channel: one word after each message's final word, tdata = mac
// cfg channel: index 0 key_size, 1..4 key words, sampled at message start
// timing: a word that is not a message's first keeps the core busy for one
//   key read wait and then nr+1 rounds of the single shared round unit; the
//   core takes the next word only after that
// the first word of a message adds the key schedule, 4*(nr+1)-nk words at
//   one per cycle, and a key read wait plus nr+1 rounds for l = aes(0)
// a mac is valid once its final word's rounds are done (after the key
//   schedule and l as well for a one-word message)
// in_tready is low while a word is being worked on and while a mac waits
// the mac is held in the output register until out_tready; the core
//   takes no new word during that time
// reset clears the message state and the key registers; data and mac registers are not reset
module aes_cmac_engine_core import acmac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // data_hi [63:0], data_lo [127:64], valid_bytes [132:128]
  input  logic         in_tlast,  // final word of the message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // mac_hi [63:0], mac_lo [127:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  state_t st_r, st_nxt;
  logic [1:0]   ksize_r;
  logic [255:0] key_r;
  logic [127:0] blk_r, chain_r, l_r, mac_r;
  logic         last_r, mid_r;
  logic [4:0]   nb_r;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         wait_r;   // wait for the registered key read
  logic         kstart, kdone;
  logic [3:0]   nr;
  logic [127:0] rkey, rnext, k1, k2, padded, blk_in;
  logic         rstep, key0, fin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r <= '0; key_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_SIZE: ksize_r <= cfg_data[1:0];
        REG_KEY_W0: key_r[255:192] <= cfg_data;
        REG_KEY_W1: key_r[191:128] <= cfg_data;
        REG_KEY_W2: key_r[127:64] <= cfg_data;
        REG_KEY_W3: key_r[63:0] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kstart = (st_r == ST_IDLE) && in_tvalid && !mid_r;

  acmac_kexp u_kexp (
    .clk(clk), .rst_n(rst_n), .start(kstart), .key_size(ksize_r), .key(key_r),
    .rd_idx(rnd_nxt), .rd_key(rkey), .done(kdone), .nr(nr)
  );

  // subkeys and padding
  assign k1 = {l_r[126:0], 1'b0} ^ {120'h0, l_r[127] ? DBL_POLY : 8'h00};
  assign k2 = {k1[126:0], 1'b0} ^ {120'h0, k1[127] ? DBL_POLY : 8'h00};
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < nb_r) padded[127-8*i -: 8] = blk_r[127-8*i -: 8];
      else if (5'(i) == nb_r) padded[127-8*i -: 8] = PAD_BYTE;
      else padded[127-8*i -: 8] = 8'h00;
    end
  end
  always_comb begin
    if (st_r == ST_SUBK) blk_in = '0;
    else if (!last_r) blk_in = blk_r ^ chain_r;
    else if (nb_r < 5'd16) blk_in = padded ^ chain_r ^ k2;
    else blk_in = blk_r ^ chain_r ^ k1;
  end

  assign rstep = (st_r == ST_SUBK || st_r == ST_BLOCK) && !wait_r;
  assign key0 = (rnd_r == 4'd0);
  assign fin = (rnd_r == nr);

  acmac_round u_round (
    .clk(clk), .start(rstep), .blk(blk_in), .rkey(rkey), .key0(key0),
    .final_rnd(fin), .nxt_state(rnext)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = mid_r ? ST_BLOCK : ST_KEXP;
      ST_KEXP: if (kdone) st_nxt = ST_SUBK;
      ST_SUBK: if (rstep && fin) st_nxt = ST_BLOCK;
      ST_BLOCK: if (rstep && fin) st_nxt = last_r ? ST_OUT : ST_IDLE;
      ST_OUT: if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // round counter, also the round key read address
  always_comb begin
    rnd_nxt = rnd_r;
    if (st_r == ST_IDLE || st_r == ST_KEXP) rnd_nxt = 4'd0;
    else if (rstep) rnd_nxt = fin ? 4'd0 : rnd_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; mid_r <= 1'b0; chain_r <= '0; wait_r <= 1'b1; rnd_r <= '0;
    end else begin
      st_r <= st_nxt;
      rnd_r <= rnd_nxt;
      wait_r <= (st_r == ST_IDLE || st_r == ST_KEXP || (rstep && fin));
      if (st_r == ST_IDLE && in_tvalid && !mid_r) chain_r <= '0;
      if (st_r == ST_BLOCK && rstep && fin) begin
        mid_r <= !last_r;
        chain_r <= last_r ? 128'h0 : rnext;
      end
    end
    if (st_r == ST_IDLE && in_tvalid) begin
      blk_r <= {in_tdata[63:0], in_tdata[127:64]};
      last_r <= in_tlast;
      nb_r <= in_tdata[132:128];
    end
    if (st_r == ST_SUBK && rstep && fin) l_r <= rnext;
    if (st_r == ST_BLOCK && rstep && fin) mac_r <= rnext;
  end

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = {mac_r[63:0], mac_r[127:64]};
endmodule

FILE: bench/aes_cmac_engine_core_tb.sv
`timescale 1ns / 1ps

module aes_cmac_engine_core_tb;
  import acmac_pkg::*;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // data_hi [63:0], data_lo [127:64], valid_bytes [132:128]
  logic         in_tlast;   // final word of the message
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // mac_hi [63:0], mac_lo [127:64]
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  localparam int unsigned WATCHDOG_CYCLES = 20000;
  localparam int unsigned DRAIN_CYCLES = 200;

  aes_cmac_engine_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor of the engine: own copy of key registers and message state
  // ---------------------------------------------------------------------------
  logic [1:0]   key_len_sel;
  logic [63:0]  key_reg [4];
  logic [127:0] cbc_state;
  logic [127:0] cipher_of_zero;
  logic [127:0] sched [15];
  int unsigned  sched_rounds;
  logic         in_message;

  logic [127:0] mac_queue [$];
  int unsigned  error_count;
  logic         stop_stall;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  task automatic build_schedule();
    logic [7:0] w [240];
    logic [7:0] t [4];
    logic [7:0] f;
    logic [7:0] rc;
    int unsigned sel, nk, total;
    sel = key_len_sel;
    if (sel == 3) sel = 2;
    nk = 4 + 2 * sel;
    sched_rounds = nk + 6;
    total = 4 * (sched_rounds + 1);
    rc = 8'h01;
    for (int i = 0; i < 240; i++) w[i] = 8'h00;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 8; j++) w[8*i+j] = key_reg[i][63 - 8*j -: 8];
    for (int i = nk; i < total; i++) begin
      for (int j = 0; j < 4; j++) t[j] = w[4*(i-1)+j];
      if (i % nk == 0) begin
        f = t[0];
        t[0] = sub_byte(t[1]) ^ rc;
        t[1] = sub_byte(t[2]);
        t[2] = sub_byte(t[3]);
        t[3] = sub_byte(f);
        rc = gf_double(rc);
      end else if (nk == 8 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) t[j] = sub_byte(t[j]);
      end
      for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-nk)+j] ^ t[j];
    end
    for (int k = 0; k < 15; k++)
      for (int i = 0; i < 16; i++) sched[k][127 - 8*i -: 8] = w[16*k+i];
  endtask

  // byte 0 of the block sits in bits 127:120
  function automatic logic [127:0] cipher_block(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8] ^ sched[0][127 - 8*i -: 8];
    for (int rnd = 1; rnd <= sched_rounds; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++) t[4*c+row] = sub_byte(s[4*((c+row)%4)+row]);
      if (rnd != sched_rounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ sched[rnd][127 - 8*i -: 8];
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = s[i];
    return r;
  endfunction

  function automatic logic [127:0] subkey_double(input logic [127:0] x);
    logic [127:0] y;
    y = {x[126:0], 1'b0};
    if (x[127]) y[7:0] = y[7:0] ^ DBL_POLY;
    return y;
  endfunction

  // one block into the predictor; returns 1 with the mac on a last block
  task automatic predict_block(input logic [127:0] blk, input logic last,
                               input logic [4:0] nbytes, output logic has_mac,
                               output logic [127:0] mac);
    logic [127:0] subkey;
    logic [127:0] m;
    has_mac = 1'b0;
    mac = '0;
    if (!in_message) begin
      build_schedule();
      cipher_of_zero = cipher_block('0);
      cbc_state = '0;
    end
    if (!last) begin
      cbc_state = cipher_block(cbc_state ^ blk);
      in_message = 1'b1;
    end else begin
      subkey = subkey_double(cipher_of_zero);
      m = blk;
      if (nbytes < 16) begin
        // short or empty final word: pad with 0x80 then zeros, use k2
        subkey = subkey_double(subkey);
        for (int i = 0; i < 16; i++) begin
          if (i == nbytes) m[127 - 8*i -: 8] = PAD_BYTE;
          else if (i > nbytes) m[127 - 8*i -: 8] = 8'h00;
        end
      end
      mac = cipher_block(cbc_state ^ m ^ subkey);
      has_mac = 1'b1;
      cbc_state = '0;
      in_message = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // idle/stall lengths: mostly short, now and then long
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall, compare against the oldest expected mac
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  logic [127:0] want_mac;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (mac_queue.size() == 0) begin
          report_mismatch("unexpected mac_hi", out_tdata[63:0], '0);
        end else begin
          want_mac = mac_queue.pop_front();
          if (out_tdata[63:0] !== want_mac[127:64])
            report_mismatch("mac_hi", out_tdata[63:0], want_mac[127:64]);
          if (out_tdata[127:64] !== want_mac[63:0])
            report_mismatch("mac_lo", out_tdata[127:64], want_mac[63:0]);
        end
      end
      if (stop_stall) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // watchdog: cycles with no word moved on any channel
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no progress");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KEY_SIZE: key_len_sel = value[1:0];
      REG_KEY_W0:   key_reg[0] = value;
      REG_KEY_W1:   key_reg[1] = value;
      REG_KEY_W2:   key_reg[2] = value;
      REG_KEY_W3:   key_reg[3] = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // key size and all four key words
  task automatic load_key(input logic [1:0] ksel, input logic [63:0] k0,
                          input logic [63:0] k1, input logic [63:0] k2,
                          input logic [63:0] k3);
    write_register(REG_KEY_SIZE, {62'd0, ksel});
    write_register(REG_KEY_W0, k0);
    write_register(REG_KEY_W1, k1);
    write_register(REG_KEY_W2, k2);
    write_register(REG_KEY_W3, k3);
  endtask

  // wait for all macs, then a bit more before touching configuration
  task automatic wait_idle();
    while (mac_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // wait until the engine is done with the word it holds
  task automatic wait_ready();
    do @(posedge clk); while (!in_tready);
  endtask

  // send one word; a known mac is checked against the predictor here too
  task automatic send_word(input logic [127:0] blk, input logic last,
                           input logic [4:0] nbytes, input logic check_known,
                           input logic [127:0] known_mac);
    logic has_mac;
    logic [127:0] mac;
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, nbytes, blk[63:0], blk[127:64]};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    predict_block(blk, last, nbytes, has_mac, mac);
    if (has_mac) begin
      if (check_known && mac !== known_mac)
        report_mismatch("predictor vs known mac_hi", mac[127:64], known_mac[127:64]);
      mac_queue.push_back(check_known ? known_mac : mac);
    end
    @(posedge clk);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [4:0] rand_tail_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 30) return 5'd16;
    if (p < 37) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(15));
  endfunction

  // ---------------------------------------------------------------------------
  // directed table; known macs are the published sp 800-38b vectors
  // ---------------------------------------------------------------------------
  typedef struct {
    logic         new_key;
    logic [1:0]   ksel;
    logic [63:0]  k [4];
    logic [127:0] blk;
    logic         last;
    logic [4:0]   nbytes;
    logic         known;
    logic [127:0] mac;
  } dir_row_t;

  localparam logic [63:0] K128_0 = 64'h2b7e151628aed2a6;
  localparam logic [63:0] K128_1 = 64'habf7158809cf4f3c;
  localparam logic [127:0] MSG0 = 128'h6bc1bee22e409f96e93d7e117393172a;
  localparam logic [127:0] MSG1 = 128'hae2d8a571e03ac9c9eb76fac45af8e51;

  dir_row_t dir_rows [$];

  task automatic add_row(input logic new_key, input logic [1:0] ksel,
                         input logic [63:0] k0, input logic [63:0] k1,
                         input logic [63:0] k2, input logic [63:0] k3,
                         input logic [127:0] blk, input logic last,
                         input logic [4:0] nbytes, input logic known,
                         input logic [127:0] mac);
    dir_row_t r;
    r.new_key = new_key; r.ksel = ksel;
    r.k[0] = k0; r.k[1] = k1; r.k[2] = k2; r.k[3] = k3;
    r.blk = blk; r.last = last; r.nbytes = nbytes; r.known = known; r.mac = mac;
    dir_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned nblk;
    dir_row_t r;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stop_stall = 1'b0;
    error_count = 0;
    key_len_sel = '0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    cbc_state = '0;
    cipher_of_zero = '0;
    sched_rounds = 10;
    in_message = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero key straight after reset, empty message
    add_row(0, 0, 0, 0, 0, 0, '0, 1, 5'd0, 0, '0);
    // aes-128 vectors: empty, one full word; then a two-word message checked by the predictor
    add_row(1, 0, K128_0, K128_1, 0, 0, '0, 1, 5'd0, 1,
            128'hbb1d6929e95937287fa37d129b756746);
    add_row(0, 0, 0, 0, 0, 0, MSG0, 1, 5'd16, 1,
            128'h070a16b46b4d4144f79bdd9dd04a287c);
    add_row(0, 0, 0, 0, 0, 0, MSG0, 0, 5'd3, 0, '0);
    add_row(0, 0, 0, 0, 0, 0, MSG1, 1, 5'd16, 0, '0);
    // aes-192 and aes-256 empty message vectors
    add_row(1, 1, 64'h8e73b0f7da0e6452, 64'hc810f32b809079e5, 64'h62f8ead2522c6b7b,
            0, '0, 1, 5'd0, 1, 128'hd17ddf46adaacde531cac483de7a9367);
    add_row(1, 2, 64'h603deb1015ca71be, 64'h2b73aef0857d7781, 64'h1f352c073b6108d7,
            64'h2d9810a30914dff4, '0, 1, 5'd0, 1, 128'h028962f61b7bf89efc6b551f4667d983);
    // key size code 3 behaves as 256; all-ones key and data
    add_row(1, 3, '1, '1, '1, '1, '1, 1, 5'd15, 0, '0);
    add_row(0, 0, 0, 0, 0, 0, '1, 0, 5'd31, 0, '0);
    add_row(0, 0, 0, 0, 0, 0, '1, 1, 5'd31, 0, '0);
    add_row(0, 0, 0, 0, 0, 0, '1, 1, 5'd17, 0, '0);
    add_row(0, 0, 0, 0, 0, 0, '1, 1, 5'd1, 0, '0);
    add_row(0, 0, 0, 0, 0, 0, 128'h0123456789abcdef0011223344556677, 1, 5'd8, 0, '0);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.new_key) begin
        wait_idle();
        load_key(r.ksel, r.k[0], r.k[1], r.k[2], r.k[3]);
      end
      send_word(r.blk, r.last, r.nbytes, r.known, r.mac);
    end

    // key written mid-message: takes effect at the next message only
    wait_idle();
    load_key(0, '0, '0, '0, '0);
    send_word(rand_block(), 0, 5'd16, 0, '0);
    wait_ready();
    write_register(REG_KEY_W0, 64'hffffffffffffffff);
    write_register(REG_KEY_SIZE, 64'd2);
    send_word(rand_block(), 1, 5'd16, 0, '0);

    // random messages, mostly short, key changed now and then between messages
    sent = 0;
    while (sent < 1250) begin
      if ($urandom_range(9) == 0) begin
        wait_idle();
        load_key(2'($urandom_range(3)), {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, {$urandom(), $urandom()});
      end
      nblk = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(3);
      for (int b = 0; b < nblk; b++) begin
        send_word(rand_block(), 0, 5'($urandom()), 0, '0);
        sent++;
      end
      send_word(rand_block(), 1, rand_tail_len(), 0, '0);
      sent++;
    end

    stop_stall = 1'b1;
    while (mac_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/acmac_pkg.sv
rtl/acmac_kexp.sv
rtl/acmac_round.sv
rtl/aes_cmac_engine_core.sv
bench/aes_cmac_engine_core_tb.sv
